### design/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit allocator package
// Shared widths, codes, payload types and controller/datapath links.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int FIELD_W   = 24;
  localparam int HDR_W     = 8;
  localparam int HEAP_BITS = 24;
  localparam int SIZE_W    = FIELD_W + 1;
  localparam int SUM_W     = FIELD_W + 2;
  localparam int ENTRY_W   = SIZE_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam longint unsigned HEAP_SPAN = (64'd1 << HEAP_BITS) - 64'd1;

  localparam logic [HDR_W-1:0]   HDR_RESET   = 8'd16;
  localparam logic [FIELD_W-1:0] LIMIT_RESET = 24'hFFFFFF;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_LIMIT     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_BYTES = 1'b0,
    CFG_HEAP_LIMIT   = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_COMMIT,
    S_SHIFT,
    S_FINISH
  } fsm_state_e;

  typedef struct packed {
    logic               action;
    logic [FIELD_W-1:0] request_size;
    logic [FIELD_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] payload_address;
    logic [2:0]         status;
    logic [FIELD_W-1:0] heap_top_now;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic decide;
    logic commit;
    logic shift;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic shift_needed;
    logic shift_done;
    logic out_free;
  } dp_status_t;

endpackage

### design/bfa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// Best-fit allocator controller
// Sequences scan, decision, commit, entry shift and result hand-off.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bfa_pkg::dp_status_t status_i,
  output bfa_pkg::ctrl_cmd_t  cmd_o
);
  import bfa_pkg::*;

  fsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.scan_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        state_d = status_i.shift_needed ? S_SHIFT : S_FINISH;
      end
      S_SHIFT: begin
        if (status_i.shift_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.start = in_valid_i;
      end
      S_SCAN:   cmd_o.scan   = 1'b1;
      S_DECIDE: cmd_o.decide = 1'b1;
      S_COMMIT: cmd_o.commit = 1'b1;
      S_SHIFT:  cmd_o.shift  = 1'b1;
      S_FINISH: cmd_o.finish = status_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

### design/bfa_datapath.sv
// ----------------------------------------------------------------------------
// Best-fit allocator datapath
// Block table memory, scan accumulators, decision logic and result register.
// ----------------------------------------------------------------------------
module bfa_datapath #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bfa_pkg::ctrl_cmd_t                cmd_i,
  output bfa_pkg::dp_status_t               status_o,
  input  bfa_pkg::in_item_t                 in_item_i,
  input  logic                              cfg_we_i,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bfa_pkg::FIELD_W-1:0]       cfg_wdata_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bfa_pkg::out_item_t                out_item_o
);
  import bfa_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  logic [HDR_W-1:0]   hdr_q;
  logic [FIELD_W-1:0] limit_q;
  logic [CW-1:0]      count_q;
  in_item_t           item_q;

  logic [CW-1:0]      rd_idx_q;
  logic               pv_q;
  logic [IW-1:0]      pidx_q;
  logic [SUM_W-1:0]   start_q;

  logic               best_found_q;
  logic [IW-1:0]      best_idx_q;
  logic [SIZE_W-1:0]  best_size_q;
  logic [SUM_W-1:0]   best_start_q;

  logic               k_found_q;
  logic [IW-1:0]      k_idx_q;
  logic [SIZE_W-1:0]  k_size_q;
  logic               k_free_q;
  logic [SUM_W-1:0]   k_start_q;
  logic               prev_valid_q;
  logic               prev_free_q;
  logic [SUM_W-1:0]   prev_span_q;
  logic               next_want_q;
  logic               next_valid_q;
  logic               next_free_q;
  logic [SUM_W-1:0]   next_span_q;
  logic               last_free_q;
  logic [SUM_W-1:0]   last_span_q;

  logic [FIELD_W-1:0] res_addr_q;
  logic [2:0]         res_status_q;
  logic [SUM_W-1:0]   res_top_q;
  logic               wr_pend_q;
  logic [IW-1:0]      wr_addr_q;
  logic [ENTRY_W-1:0] wr_data_q;
  logic [CW-1:0]      new_count_q;
  logic               shift_needed_q;
  logic [CW-1:0]      shift_src_q;
  logic [CW-1:0]      shift_end_q;
  logic [1:0]         shift_r_q;

  logic               out_valid_q;
  out_item_t          out_q;

  logic [HDR_W-1:0]   hdr_eff;
  logic [FIELD_W-1:0] limit_eff;
  logic [FIELD_W-1:0] req_eff;
  logic [ENTRY_W-1:0] rd_data;
  logic [SIZE_W-1:0]  e_size;
  logic               e_free;
  logic [SUM_W-1:0]   e_span;
  logic [CW-1:0]      rd_lim;
  logic               rd_en;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               out_free;

  logic               fit_hit;
  logic               addr_hit;
  logic               nf;
  logic               pf;
  logic [CW-1:0]      idx_end;
  logic               is_last;
  logic [IW-1:0]      m_idx;
  logic [SUM_W-1:0]   merged;
  logic [SUM_W-1:0]   app_top;

  assign hdr_eff   = (hdr_q == '0) ? HDR_W'(1) : hdr_q;
  assign limit_eff = (64'(limit_q) < HEAP_SPAN) ? limit_q : HEAP_SPAN[FIELD_W-1:0];
  assign req_eff   = item_q.request_size & FIELD_W'(HEAP_SPAN);

  assign e_size = rd_data[SIZE_W-1:0];
  assign e_free = rd_data[SIZE_W];
  assign e_span = SUM_W'(hdr_eff) + SUM_W'(e_size);

  assign rd_lim = cmd_i.shift ? shift_end_q : count_q;
  assign rd_en  = (cmd_i.scan || cmd_i.shift) && (rd_idx_q < rd_lim);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_q;
    ram_wdata = wr_data_q;
    if (cmd_i.commit && wr_pend_q) begin
      ram_we = 1'b1;
    end else if (cmd_i.shift && pv_q) begin
      ram_we    = 1'b1;
      ram_waddr = pidx_q - IW'(shift_r_q);
      ram_wdata = rd_data;
    end
  end

  bfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q[IW-1:0]),
    .rd_data_o (rd_data)
  );

  assign fit_hit = (item_q.action == ACT_ALLOC) && e_free &&
                   (e_size >= SIZE_W'(req_eff)) &&
                   (!best_found_q || (e_size < best_size_q));
  assign addr_hit = (item_q.action == ACT_FREE) && !k_found_q &&
                    (item_q.free_address != '0) &&
                    ((start_q + SUM_W'(hdr_eff)) == SUM_W'(item_q.free_address));

  assign nf      = next_valid_q && next_free_q;
  assign pf      = prev_valid_q && prev_free_q;
  assign idx_end = CW'(k_idx_q) + CW'(nf);
  assign is_last = (idx_end == (count_q - CW'(1)));
  assign m_idx   = k_idx_q - IW'(pf);
  assign merged  = SUM_W'(k_size_q) + (nf ? next_span_q : '0) + (pf ? prev_span_q : '0);
  assign app_top = start_q + SUM_W'(hdr_eff) + SUM_W'(req_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q   <= HDR_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_HEADER_BYTES: hdr_q   <= cfg_wdata_i[HDR_W-1:0];
        CFG_HEAP_LIMIT:   limit_q <= cfg_wdata_i;
        default: begin
          hdr_q <= hdr_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
      pv_q     <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        rd_idx_q <= '0;
        pv_q     <= 1'b0;
      end else if (cmd_i.scan || cmd_i.shift) begin
        pv_q <= rd_en;
        if (rd_en) rd_idx_q <= rd_idx_q + CW'(1);
      end else if (cmd_i.commit) begin
        count_q  <= new_count_q;
        rd_idx_q <= shift_src_q;
        pv_q     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) pidx_q <= rd_idx_q[IW-1:0];
    if (cmd_i.start) begin
      item_q       <= in_item_i;
      start_q      <= '0;
      best_found_q <= 1'b0;
      k_found_q    <= 1'b0;
      next_want_q  <= 1'b0;
      next_valid_q <= 1'b0;
      last_free_q  <= 1'b0;
      last_span_q  <= '0;
    end else if (cmd_i.scan && pv_q) begin
      start_q     <= start_q + e_span;
      last_free_q <= e_free;
      last_span_q <= e_span;
      if (fit_hit) begin
        best_found_q <= 1'b1;
        best_idx_q   <= pidx_q;
        best_size_q  <= e_size;
        best_start_q <= start_q;
      end
      if (addr_hit) begin
        k_found_q    <= 1'b1;
        k_idx_q      <= pidx_q;
        k_size_q     <= e_size;
        k_free_q     <= e_free;
        k_start_q    <= start_q;
        prev_valid_q <= (pidx_q != '0);
        prev_free_q  <= last_free_q;
        prev_span_q  <= last_span_q;
        next_want_q  <= 1'b1;
      end else if (next_want_q) begin
        next_want_q  <= 1'b0;
        next_valid_q <= 1'b1;
        next_free_q  <= e_free;
        next_span_q  <= e_span;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      res_addr_q     <= '0;
      res_status_q   <= ST_OK;
      res_top_q      <= start_q;
      wr_pend_q      <= 1'b0;
      wr_addr_q      <= count_q[IW-1:0];
      wr_data_q      <= {1'b0, SIZE_W'(req_eff)};
      new_count_q    <= count_q;
      shift_needed_q <= 1'b0;
      shift_src_q    <= CW'(k_idx_q) + CW'(1) + CW'(nf);
      shift_end_q    <= count_q;
      shift_r_q      <= 2'(pf) + 2'(nf);
      if (item_q.action == ACT_ALLOC) begin
        if (best_found_q) begin
          wr_pend_q  <= 1'b1;
          wr_addr_q  <= best_idx_q;
          wr_data_q  <= {1'b0, best_size_q};
          res_addr_q <= FIELD_W'(best_start_q + SUM_W'(hdr_eff));
        end else if (count_q >= CW'(MAX_BLOCKS)) begin
          res_status_q <= ST_FULL;
        end else if (app_top > SUM_W'(limit_eff)) begin
          res_status_q <= ST_LIMIT;
        end else begin
          wr_pend_q   <= 1'b1;
          new_count_q <= count_q + CW'(1);
          res_addr_q  <= FIELD_W'(start_q + SUM_W'(hdr_eff));
          res_top_q   <= app_top;
        end
      end else begin
        if (item_q.free_address == '0) begin
          res_status_q <= ST_IGNORED;
        end else if (!k_found_q) begin
          res_status_q <= ST_NOT_FOUND;
        end else if (k_free_q) begin
          res_status_q <= ST_IGNORED;
        end else if (is_last) begin
          new_count_q <= CW'(m_idx);
          res_top_q   <= k_start_q - (pf ? prev_span_q : '0);
        end else begin
          wr_pend_q      <= 1'b1;
          wr_addr_q      <= m_idx;
          wr_data_q      <= {1'b1, merged[SIZE_W-1:0]};
          new_count_q    <= count_q - CW'(pf) - CW'(nf);
          shift_needed_q <= pf || nf;
        end
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.payload_address <= res_addr_q;
      out_q.status          <= res_status_q;
      out_q.heap_top_now    <= res_top_q[FIELD_W-1:0];
    end
  end

  assign status_o.scan_done    = (rd_idx_q >= count_q) && !pv_q;
  assign status_o.shift_needed = shift_needed_q;
  assign status_o.shift_done   = (rd_idx_q >= shift_end_q) && !pv_q;
  assign status_o.out_free     = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### design/best_fit_block_allocator_unit.sv
// Each beat in is one allocate or free, answered by one result beat. The block
// table lives in a memory with registered read that is walked once per item. With
// N live blocks, the scan, decide, commit and hand-off follow in that order. A
// free that coalesces and has to close the gap behind the merged block moves the
// M entries behind it, at most N - 2, between the commit and the hand-off. The
// next beat is taken in the cycle after the hand-off, even while the previous
// result still waits in the output register; the hand-off itself waits only
// while an earlier result has not been accepted.
// ----------------------------------------------------------------------------
// Best-fit block allocator top level
// Address-ordered heap block table with best-fit reuse and coalescing free.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_unit #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bfa_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bfa_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bfa_pkg::FIELD_W-1:0]   cfg_wdata_i
);
  import bfa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  bfa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("Block accepted a beat while still busy.");

  a_finish_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o)
    else $error("Finished item did not reach the output register.");

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start, cmd.scan, cmd.decide, cmd.commit, cmd.shift, cmd.finish}))
    else $error("Controller issued more than one command.");

endmodule
